### sv/nlsc_pkg.sv
// ----------------------------------------------------------------------------
// nlsc_pkg
// Shared types, codes and clamp helpers of the notification LED strobe
// controller.
// ----------------------------------------------------------------------------
package nlsc_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned TmoW     = 11;
  localparam int unsigned OffW     = 14;
  localparam int unsigned OnW      = 10;
  localparam int unsigned CntW     = 4;
  localparam int unsigned GapW     = 7;
  localparam int unsigned TimerW   = 14;
  localparam int unsigned TmoLeftW = 27;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  // commands
  localparam logic [CmdW-1:0] CMD_TICK       = 3'd0;
  localparam logic [CmdW-1:0] CMD_NOTIFY_ON  = 3'd1;
  localparam logic [CmdW-1:0] CMD_NOTIFY_OFF = 3'd2;
  localparam logic [CmdW-1:0] CMD_SUSPEND    = 3'd3;
  localparam logic [CmdW-1:0] CMD_RESUME     = 3'd4;
  localparam logic [CmdW-1:0] CMD_TOUCH      = 3'd5;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OFF_MS    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ON_MS     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STROBE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GAP_MS    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_KEEP_LIT  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_TOUCH_EN  = 3'd7;

  // blink phases
  localparam logic [PhaseW-1:0] PH_WAIT = 2'd0;
  localparam logic [PhaseW-1:0] PH_LIT  = 2'd1;
  localparam logic [PhaseW-1:0] PH_GAP  = 2'd2;

  localparam int unsigned MinFlashMs  = 5;
  localparam int unsigned FirstWaitMs = 500;
  localparam int unsigned MsPerSec    = 1000;
  localparam int unsigned SecPerMin   = 60;
  localparam int unsigned MaxStrobe   = 10;
  localparam int unsigned MaxGapMs    = 100;
  localparam int unsigned MinOnMs     = 10;
  localparam int unsigned MaxOnMs     = 1000;
  localparam int unsigned MinOffMs    = 1000;
  localparam int unsigned MaxOffMs    = 10000;
  localparam int unsigned MaxOffSec   = MaxOffMs / MsPerSec;

  localparam logic [LevelW-1:0]   FullLevel = 8'd255;
  localparam logic [TimerW-1:0]   FirstWait = TimerW'((FirstWaitMs / MsPerSec) * MsPerSec);
  localparam logic [TmoLeftW-1:0] MsPerMin  = TmoLeftW'(SecPerMin * MsPerSec);

  typedef struct packed {
    logic              enable;
    logic [TmoW-1:0]   timeout_minutes;
    logic [OffW-1:0]   off_period_ms;
    logic [OnW-1:0]    on_period_ms;
    logic [CntW-1:0]   strobe_count;
    logic [GapW-1:0]   strobe_gap_ms;
    logic              keep_lit;
    logic              touch_light_enable;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    enable:             1'b0,
    timeout_minutes:    11'd0,
    off_period_ms:      14'd7000,
    on_period_ms:       10'd40,
    strobe_count:       4'd0,
    strobe_gap_ms:      7'd40,
    keep_lit:           1'b0,
    touch_light_enable: 1'b1
  };

  typedef struct packed {
    logic                led_lit;
    logic                notify_on;
    logic                notify_ongoing;
    logic                is_suspended;
    logic                blink_armed;
    logic [PhaseW-1:0]   phase;
    logic [TimerW-1:0]   phase_timer;
    logic [CntW-1:0]     flash_index;
    logic [TmoLeftW-1:0] timeout_left;
  } state_t;

  function automatic logic [OnW-1:0] on_clamp(input logic [OnW-1:0] v);
    if (v < OnW'(MinOnMs)) return OnW'(MinOnMs);
    if (v > OnW'(MaxOnMs)) return OnW'(MaxOnMs);
    return v;
  endfunction

  function automatic logic [CntW-1:0] count_clamp(input logic [CntW-1:0] v);
    if (v > CntW'(MaxStrobe)) return CntW'(MaxStrobe);
    if (v < CntW'(1)) return CntW'(1);
    return v;
  endfunction

  function automatic logic [GapW-1:0] gap_clamp(input logic [GapW-1:0] v);
    return (v > GapW'(MaxGapMs)) ? GapW'(MaxGapMs) : v;
  endfunction

  // clamp, then round down to whole seconds
  function automatic logic [TimerW-1:0] off_wait(input logic [OffW-1:0] v);
    logic [OffW-1:0]   oc;
    logic [TimerW-1:0] w;
    oc = v;
    if (v < OffW'(MinOffMs)) oc = OffW'(MinOffMs);
    if (v > OffW'(MaxOffMs)) oc = OffW'(MaxOffMs);
    w = '0;
    for (int k = 1; k <= MaxOffSec; k++) begin
      if (oc >= OffW'(k * MsPerSec)) w = TimerW'(k * MsPerSec);
    end
    return w;
  endfunction

endpackage

### sv/nlsc_div.sv
// ----------------------------------------------------------------------------
// nlsc_div
// Restoring divider, one quotient bit per cycle; splits the on period over
// the flashes of a burst.
// ----------------------------------------------------------------------------
module nlsc_div
  import nlsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OnW-1:0]  dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            done_o,
  output logic [OnW-1:0]  quotient_o
);

  localparam int unsigned StepW = $clog2(OnW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [OnW-1:0]   quot_q, quot_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dvs_q, dvs_d;
  logic [CntW:0]    trial;
  logic [CntW:0]    diff;
  logic             fits;

  assign trial = {rem_q, quot_q[OnW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[CntW-1:0] : trial[CntW-1:0];
      quot_d = {quot_q[OnW-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == StepW'(OnW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

### sv/nlsc_step.sv
// ----------------------------------------------------------------------------
// nlsc_step
// Next-state logic for one event: tick timing, notification control and
// touch override.
// ----------------------------------------------------------------------------
module nlsc_step
  import nlsc_pkg::*;
(
  input  cfg_t              cfg_i,
  input  state_t            state_i,
  input  logic [CmdW-1:0]   command_i,
  input  logic [LevelW-1:0] touch_value_i,
  input  logic [OnW-1:0]    quotient_i,
  output state_t            state_o,
  output logic [LevelW-1:0] touch_result_o
);

  function automatic state_t disarm(input state_t st);
    state_t r;
    r             = st;
    r.blink_armed = 1'b0;
    r.phase       = PH_WAIT;
    r.phase_timer = '0;
    r.flash_index = '0;
    return r;
  endfunction

  logic [CntW-1:0]   count_c;
  logic [OnW-1:0]    flash_len;
  logic [TimerW-1:0] flash_t;
  logic [TimerW-1:0] gap_t;
  logic [TimerW-1:0] off_t;
  logic [CntW:0]     next_index;
  state_t            s;
  logic [LevelW-1:0] touch;

  assign count_c = count_clamp(cfg_i.strobe_count);
  assign flash_len = (count_c == CntW'(1)) ? on_clamp(cfg_i.on_period_ms) :
                     (quotient_i < OnW'(MinFlashMs)) ? OnW'(MinFlashMs) : quotient_i;
  assign flash_t = TimerW'(flash_len);
  assign gap_t   = TimerW'(gap_clamp(cfg_i.strobe_gap_ms));
  assign off_t   = off_wait(cfg_i.off_period_ms);
  assign next_index = {1'b0, state_i.flash_index} + 1'b1;

  always_comb begin
    s     = state_i;
    touch = '0;
    unique case (command_i)
      CMD_TICK: begin
        if (s.timeout_left != '0) s.timeout_left = s.timeout_left - 1'b1;
        if (s.blink_armed) begin
          unique case (s.phase)
            PH_WAIT: begin
              if (s.phase_timer != '0) begin
                s.phase_timer = s.phase_timer - 1'b1;
              end else if (!(cfg_i.enable && s.notify_on)) begin
                s = disarm(s);
              end else if (cfg_i.timeout_minutes != '0 && s.timeout_left == '0) begin
                s.notify_on = 1'b0;
                s = disarm(s);
              end else begin
                s.flash_index = '0;
                s.led_lit     = 1'b1;
                s.phase       = PH_LIT;
                s.phase_timer = flash_t;
              end
            end
            PH_LIT: begin
              if (s.phase_timer != '0) s.phase_timer = s.phase_timer - 1'b1;
              if (s.phase_timer == '0) begin
                if (next_index < {1'b0, count_c}) begin
                  s.led_lit     = 1'b0;
                  s.phase       = PH_GAP;
                  s.phase_timer = gap_t;
                  // zero gap: next flash starts on this tick
                  if (gap_t == '0) begin
                    s.flash_index = next_index[CntW-1:0];
                    s.led_lit     = 1'b1;
                    s.phase       = PH_LIT;
                    s.phase_timer = flash_t;
                  end
                end else begin
                  if (!cfg_i.keep_lit) s.led_lit = 1'b0;
                  if (cfg_i.enable && s.notify_on) begin
                    s.phase       = PH_WAIT;
                    s.phase_timer = off_t;
                    s.flash_index = '0;
                  end else begin
                    s = disarm(s);
                  end
                end
              end
            end
            PH_GAP: begin
              if (s.phase_timer != '0) s.phase_timer = s.phase_timer - 1'b1;
              if (s.phase_timer == '0) begin
                s.flash_index = next_index[CntW-1:0];
                s.led_lit     = 1'b1;
                s.phase       = PH_LIT;
                s.phase_timer = flash_t;
              end
            end
            default: s = disarm(s);
          endcase
        end
      end
      CMD_NOTIFY_ON: begin
        if (cfg_i.enable && s.is_suspended) begin
          s.notify_on = 1'b1;
          if (cfg_i.timeout_minutes != '0 && !s.notify_ongoing) begin
            s.timeout_left = TmoLeftW'(cfg_i.timeout_minutes) * MsPerMin;
          end
          s.blink_armed    = 1'b1;
          s.phase          = PH_WAIT;
          s.phase_timer    = FirstWait;
          s.flash_index    = '0;
          s.notify_ongoing = 1'b1;
        end
      end
      CMD_NOTIFY_OFF: begin
        s.notify_on      = 1'b0;
        s.notify_ongoing = 1'b0;
        s = disarm(s);
        if (s.is_suspended) s.led_lit = 1'b0;
      end
      CMD_SUSPEND: s.is_suspended = 1'b1;
      CMD_RESUME: begin
        s.is_suspended = 1'b0;
        s.notify_on    = 1'b0;
        s = disarm(s);
      end
      CMD_TOUCH: begin
        if (touch_value_i != '0) begin
          touch = (s.notify_on || cfg_i.touch_light_enable) ? touch_value_i : '0;
        end else begin
          touch = s.notify_on ? FullLevel : '0;
        end
      end
      default: ;
    endcase
  end

  assign state_o        = s;
  assign touch_result_o = touch;

endmodule

### sv/notification_led_strobe_controller_core.sv
// ----------------------------------------------------------------------------
// notification_led_strobe_controller_core
// Notification LED blink and strobe controller driven by one event per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event: a 1 ms tick,
//   notify on/off, suspend, resume or a touch request with its value.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   event: LED level, touch override, notification and blink flags.
//   Configuration writes use cfg_valid_i / cfg_ready_o with a register index
//   and data; they are taken only between items and win over a waiting item.
// Timing:
//   Each item runs the shared restoring divider (on period / flash count);
//   once the quotient is ready, the apply state updates the state and
//   registers the result. A new item is accepted only after the previous one
//   has been applied and the controller is back in idle.
// Reset and stall:
//   Reset clears all state and loads the register defaults. The result sits in
//   an output register; a stalled result holds, and the next item is accepted
//   and worked on, waiting before its update until the output register frees.
// ----------------------------------------------------------------------------
module notification_led_strobe_controller_core
  import nlsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CmdW-1:0]     command_i,
  input  logic [LevelW-1:0]   touch_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LevelW-1:0]   led_level_o,
  output logic [LevelW-1:0]   touch_result_o,
  output logic                notification_active_o,
  output logic                blinking_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]        fsm_q, fsm_d;
  cfg_t              cfg_q, cfg_d;
  state_t            st_q, st_d;
  logic              out_valid_q, out_valid_d;
  logic [CmdW-1:0]   cmd_q;
  logic [LevelW-1:0] tv_q;
  logic [LevelW-1:0] led_q, touch_q;
  logic              active_q, blink_q;

  logic              take_item;
  logic              load_out;
  logic              div_done;
  logic [OnW-1:0]    quotient;
  state_t            step_state;
  logic [LevelW-1:0] step_touch;

  assign cfg_ready_o = (fsm_q == ST_IDLE);
  assign in_stall_o  = (fsm_q != ST_IDLE) || cfg_valid_i;
  assign take_item   = in_valid_i && !in_stall_o;
  assign load_out    = (fsm_q == ST_APPLY) && (!out_valid_q || !out_stall_i);

  nlsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (take_item),
    .dividend_i (on_clamp(cfg_q.on_period_ms)),
    .divisor_i  (count_clamp(cfg_q.strobe_count)),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  nlsc_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (st_q),
    .command_i      (cmd_q),
    .touch_value_i  (tv_q),
    .quotient_i     (quotient),
    .state_o        (step_state),
    .touch_result_o (step_touch)
  );

  always_comb begin
    fsm_d       = fsm_q;
    cfg_d       = cfg_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (fsm_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          unique case (cfg_index_i)
            REG_ENABLE: begin
              cfg_d.enable = cfg_data_i[0];
              // disabling drops a running notification
              if (!cfg_data_i[0] && st_q.notify_on) begin
                st_d.notify_on      = 1'b0;
                st_d.notify_ongoing = 1'b0;
                st_d.blink_armed    = 1'b0;
                st_d.phase          = PH_WAIT;
                st_d.phase_timer    = '0;
                st_d.flash_index    = '0;
                if (st_q.is_suspended) st_d.led_lit = 1'b0;
              end
            end
            REG_TIMEOUT:  cfg_d.timeout_minutes = cfg_data_i[TmoW-1:0];
            REG_OFF_MS:   cfg_d.off_period_ms   = cfg_data_i[OffW-1:0];
            REG_ON_MS:    cfg_d.on_period_ms    = cfg_data_i[OnW-1:0];
            REG_STROBE:   cfg_d.strobe_count    = cfg_data_i[CntW-1:0];
            REG_GAP_MS:   cfg_d.strobe_gap_ms   = cfg_data_i[GapW-1:0];
            REG_KEEP_LIT: cfg_d.keep_lit        = cfg_data_i[0];
            REG_TOUCH_EN: begin
              // edge of the touch enable follows onto the LED
              if (cfg_data_i[0] != cfg_q.touch_light_enable) st_d.led_lit = cfg_data_i[0];
              cfg_d.touch_light_enable = cfg_data_i[0];
            end
            default: ;
          endcase
        end else if (take_item) begin
          fsm_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) fsm_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (load_out) begin
          st_d        = step_state;
          out_valid_d = 1'b1;
          fsm_d       = ST_IDLE;
        end
      end
      default: fsm_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      cfg_q       <= CfgReset;
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      cfg_q       <= cfg_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_item) begin
      cmd_q <= command_i;
      tv_q  <= touch_value_i;
    end
    if (load_out) begin
      led_q    <= step_state.led_lit ? FullLevel : '0;
      touch_q  <= step_touch;
      active_q <= step_state.notify_on;
      blink_q  <= step_state.blink_armed;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign led_level_o           = led_q;
  assign touch_result_o        = touch_q;
  assign notification_active_o = active_q;
  assign blinking_o            = blink_q;

endmodule
